>>> design/rsps_pkg.sv
package rsps_pkg;

    localparam int unsigned PosW    = 16;
    localparam int unsigned StepW   = 8;
    localparam int unsigned CountW  = 8;
    localparam int unsigned SampleW = 10;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 16;

    typedef enum logic [CfgIdxW-1:0] {
        REG_MEAS_PER_POINT = 3'd0,
        REG_H_MIN          = 3'd1,
        REG_H_MAX          = 3'd2,
        REG_H_STEP         = 3'd3,
        REG_V_MIN          = 3'd4,
        REG_V_MAX          = 3'd5,
        REG_V_STEP         = 3'd6
    } t_reg_idx;

    typedef enum logic {
        MODE_START  = 1'b0,
        MODE_SAMPLE = 1'b1
    } t_mode;

    typedef struct packed {
        logic [CountW-1:0] meas_per_point;
        logic [PosW-1:0]   h_min;
        logic [PosW-1:0]   h_max;
        logic [StepW-1:0]  h_step;
        logic [PosW-1:0]   v_min;
        logic [PosW-1:0]   v_max;
        logic [StepW-1:0]  v_step;
    } t_cfg;

endpackage

>>> design/rsps_if.sv
interface rsps_in_if
    import rsps_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               mode;
    logic [SampleW-1:0] sample;

    modport source (output valid, output mode, output sample, input ready);
    modport sink   (input valid, input mode, input sample, output ready);
endinterface

interface rsps_out_if
    import rsps_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PosW-1:0]    meas_h;
    logic [PosW-1:0]    meas_v;
    logic [SampleW-1:0] sample_value;
    logic               scan_done;

    modport source (output valid, output meas_h, output meas_v, output sample_value,
                    output scan_done, input ready);
    modport sink   (input valid, input meas_h, input meas_v, input sample_value,
                    input scan_done, output ready);
endinterface

>>> design/rsps_cfg_regs.sv
module rsps_cfg_regs
    import rsps_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_MEAS_PER_POINT: n_cfg.meas_per_point = i_cfg_data[CountW-1:0];
                REG_H_MIN:          n_cfg.h_min          = i_cfg_data[PosW-1:0];
                REG_H_MAX:          n_cfg.h_max          = i_cfg_data[PosW-1:0];
                REG_H_STEP:         n_cfg.h_step         = i_cfg_data[StepW-1:0];
                REG_V_MIN:          n_cfg.v_min          = i_cfg_data[PosW-1:0];
                REG_V_MAX:          n_cfg.v_max          = i_cfg_data[PosW-1:0];
                REG_V_STEP:         n_cfg.v_step         = i_cfg_data[StepW-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/raster_scan_position_sequencer.sv
// Latency: a sample item's result is valid in the cycle after the item is accepted.
// Throughput: one item per cycle; the result register is refilled whenever it is
// empty or being taken, so input ready only drops while a result waits unread.
// Reset: synchronous, active low; clears all configuration registers, the position,
// the count and the scanning flag, and empties the result register.
module raster_scan_position_sequencer
    import rsps_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    rsps_in_if.sink             i_in,
    rsps_out_if.source          o_out
);

    t_cfg cfg;

    logic [PosW-1:0]    r_h_pos, n_h_pos;
    logic [PosW-1:0]    r_v_pos, n_v_pos;
    logic [CountW-1:0]  r_count, n_count;
    logic               r_scanning, n_scanning;
    logic               r_out_valid, n_out_valid;
    logic [PosW-1:0]    r_meas_h, n_meas_h;
    logic [PosW-1:0]    r_meas_v, n_meas_v;
    logic [SampleW-1:0] r_sample, n_sample;
    logic               r_done, n_done;

    logic              accept;
    logic              produce;
    logic [CountW:0]   count_inc;
    logic              point_end;
    logic [PosW-1:0]   h_add;
    logic [PosW-1:0]   v_add;
    logic [PosW-1:0]   adv_h;
    logic [PosW-1:0]   adv_v;

    rsps_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign produce    = accept && (t_mode'(i_in.mode) == MODE_SAMPLE) && r_scanning;

    assign count_inc = {1'b0, r_count} + {{CountW{1'b0}}, 1'b1};
    assign point_end = count_inc > {1'b0, cfg.meas_per_point};
    assign h_add     = r_h_pos + {{(PosW-StepW-1){1'b0}}, cfg.h_step, 1'b0};
    assign v_add     = r_v_pos + {{(PosW-StepW-1){1'b0}}, cfg.v_step, 1'b0};

    always_comb begin
        adv_h = r_h_pos;
        adv_v = r_v_pos;
        if (point_end) begin
            if (r_h_pos == cfg.h_max) begin
                adv_h = cfg.h_min;
                adv_v = v_add;
            end else if (h_add > cfg.h_max) begin
                adv_h = cfg.h_max;
            end else begin
                adv_h = h_add;
            end
        end
    end

    always_comb begin
        n_h_pos     = r_h_pos;
        n_v_pos     = r_v_pos;
        n_count     = r_count;
        n_scanning  = r_scanning;
        n_out_valid = r_out_valid && !o_out.ready;
        n_meas_h    = r_meas_h;
        n_meas_v    = r_meas_v;
        n_sample    = r_sample;
        n_done      = r_done;
        if (accept && (t_mode'(i_in.mode) == MODE_START)) begin
            n_h_pos    = cfg.h_min;
            n_v_pos    = cfg.v_min;
            n_count    = '0;
            n_scanning = 1'b1;
        end else if (produce) begin
            n_h_pos     = adv_h;
            n_v_pos     = adv_v;
            n_count     = point_end ? '0 : count_inc[CountW-1:0];
            n_scanning  = !(adv_v > cfg.v_max);
            n_out_valid = 1'b1;
            n_meas_h    = r_h_pos;
            n_meas_v    = r_v_pos;
            n_sample    = i_in.sample;
            n_done      = adv_v > cfg.v_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_pos     <= '0;
            r_v_pos     <= '0;
            r_count     <= '0;
            r_scanning  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_h_pos     <= n_h_pos;
            r_v_pos     <= n_v_pos;
            r_count     <= n_count;
            r_scanning  <= n_scanning;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_meas_h <= n_meas_h;
        r_meas_v <= n_meas_v;
        r_sample <= n_sample;
        r_done   <= n_done;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.meas_h       = r_meas_h;
    assign o_out.meas_v       = r_meas_v;
    assign o_out.sample_value = r_sample;
    assign o_out.scan_done    = r_done;

endmodule

>>> bench/raster_scan_position_sequencer_test.sv
module raster_scan_position_sequencer_test;
    import rsps_pkg::*;

    typedef struct packed {
        logic [PosW-1:0]    h;
        logic [PosW-1:0]    v;
        logic [SampleW-1:0] smp;
        logic               done;
    } t_point_result;

    typedef enum logic {ROW_WRITE, ROW_ITEM} t_row_kind;
    typedef enum logic [1:0] {WANT_NONE, WANT_GIVEN, WANT_PREDICTED} t_want;

    typedef struct {
        t_row_kind          kind;
        t_reg_idx           idx;
        logic [CfgDataW-1:0] data;
        t_mode              mode;
        logic [SampleW-1:0] smp;
        t_want              want;
        t_point_result      expected;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;

    rsps_in_if  in_if ();
    rsps_out_if out_if ();

    raster_scan_position_sequencer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    t_cfg              scan_cfg;
    logic [PosW-1:0]   scan_h;
    logic [PosW-1:0]   scan_v;
    logic [CountW-1:0] scan_count;
    bit                scan_active;

    t_point_result pending_labels[$];
    int unsigned   error_count;
    bit            steady;
    bit            hold_req;
    bit            hold_seen;
    int unsigned   hold_left;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic note_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    // Mirrors the scan state for one accepted item and returns the labeled sample.
    function automatic void label_sample(input t_mode m, input logic [SampleW-1:0] s,
                                         output bit produced, output t_point_result r);
        logic [CountW:0] next_count;
        logic [PosW-1:0] next_h;
        produced = 1'b0;
        r = '0;
        if (m == MODE_START) begin
            scan_h = scan_cfg.h_min;
            scan_v = scan_cfg.v_min;
            scan_count = '0;
            scan_active = 1'b1;
        end else if (scan_active) begin
            produced = 1'b1;
            r.h = scan_h;
            r.v = scan_v;
            r.smp = s;
            next_count = {1'b0, scan_count} + 1'b1;
            if (next_count > {1'b0, scan_cfg.meas_per_point}) begin
                scan_count = '0;
                if (scan_h == scan_cfg.h_max) begin
                    scan_h = scan_cfg.h_min;
                    scan_v = scan_v + {7'd0, scan_cfg.v_step, 1'b0};
                end else begin
                    next_h = scan_h + {7'd0, scan_cfg.h_step, 1'b0};
                    scan_h = (next_h > scan_cfg.h_max) ? scan_cfg.h_max : next_h;
                end
            end else begin
                scan_count = next_count[CountW-1:0];
            end
            r.done = (scan_v > scan_cfg.v_max);
            if (r.done) begin
                scan_active = 1'b0;
            end
        end
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [CfgDataW-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_MEAS_PER_POINT: scan_cfg.meas_per_point = data[CountW-1:0];
            REG_H_MIN:          scan_cfg.h_min = data;
            REG_H_MAX:          scan_cfg.h_max = data;
            REG_H_STEP:         scan_cfg.h_step = data[StepW-1:0];
            REG_V_MIN:          scan_cfg.v_min = data;
            REG_V_MAX:          scan_cfg.v_max = data;
            REG_V_STEP:         scan_cfg.v_step = data[StepW-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic offer_item(input t_mode m, input logic [SampleW-1:0] s,
                              output bit produced, output t_point_result r);
        while (!steady && $urandom_range(99) < 18) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.mode <= m;
        in_if.sample <= s;
        do @(posedge i_clk); while (!in_if.ready);
        label_sample(m, s, produced, r);
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_labels.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    function automatic t_row write_row(input t_reg_idx idx, input logic [CfgDataW-1:0] data);
        t_row row;
        row = '{ROW_WRITE, idx, data, MODE_START, '0, WANT_NONE, '0};
        return row;
    endfunction

    function automatic t_row item_row(input t_mode m, input logic [SampleW-1:0] s,
                                      input t_want w, input t_point_result e);
        t_row row;
        row = '{ROW_ITEM, REG_MEAS_PER_POINT, '0, m, s, w, e};
        return row;
    endfunction

    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = 70;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= steady || ($urandom_range(99) >= 18);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_point_result got;
        t_point_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = '{out_if.meas_h, out_if.meas_v, out_if.sample_value, out_if.scan_done};
            if (pending_labels.size() == 0) begin
                note_mismatch($sformatf("unexpected result h=%0d v=%0d", got.h, got.v));
            end else begin
                want = pending_labels.pop_front();
                if (got.h !== want.h)
                    note_mismatch($sformatf("meas_h %0d, want %0d", got.h, want.h));
                if (got.v !== want.v)
                    note_mismatch($sformatf("meas_v %0d, want %0d", got.v, want.v));
                if (got.smp !== want.smp)
                    note_mismatch($sformatf("sample_value %0d, want %0d", got.smp, want.smp));
                if (got.done !== want.done)
                    note_mismatch($sformatf("scan_done %0b, want %0b", got.done, want.done));
            end
        end
    end

    initial begin
        #6000000;
        $display("raster_scan_position_sequencer_test: done, errors");
        $finish;
    end

    initial begin
        t_row              plan[$];
        bit                produced;
        t_point_result     res;
        t_mode             m;
        logic [PosW-1:0]   base;
        logic [CfgDataW-1:0] vals[7];
        int unsigned       quota;
        int unsigned       counted;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_MEAS_PER_POINT;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.mode = MODE_START;
        in_if.sample = '0;
        out_if.ready = 1'b0;
        steady = 1'b0;
        hold_req = 1'b0;
        hold_seen = 1'b0;
        hold_left = 0;
        error_count = 0;
        scan_cfg = '0;
        scan_h = '0;
        scan_v = '0;
        scan_count = '0;
        scan_active = 1'b0;

        plan = '{
            item_row(MODE_SAMPLE, 10'h3FF, WANT_NONE, '0),
            item_row(MODE_START, 10'h000, WANT_NONE, '0),
            item_row(MODE_SAMPLE, 10'h3FF, WANT_GIVEN, '{16'd0, 16'd0, 10'h3FF, 1'b0}),
            item_row(MODE_SAMPLE, 10'h000, WANT_GIVEN, '{16'd0, 16'd0, 10'h000, 1'b0}),
            write_row(REG_V_MIN, 16'd5),
            write_row(REG_V_MAX, 16'd4),
            item_row(MODE_START, 10'h000, WANT_NONE, '0),
            item_row(MODE_SAMPLE, 10'h155, WANT_GIVEN, '{16'd0, 16'd5, 10'h155, 1'b1}),
            item_row(MODE_SAMPLE, 10'h2AA, WANT_NONE, '0),
            write_row(REG_H_MIN, 16'hFFF0),
            write_row(REG_H_MAX, 16'hFFFF),
            write_row(REG_H_STEP, 16'h00FF),
            write_row(REG_V_MIN, 16'h0000),
            write_row(REG_V_MAX, 16'hFFFF),
            write_row(REG_V_STEP, 16'h00FF),
            item_row(MODE_START, 10'h3FF, WANT_NONE, '0),
            item_row(MODE_SAMPLE, 10'h001, WANT_GIVEN, '{16'hFFF0, 16'd0, 10'h001, 1'b0}),
            item_row(MODE_SAMPLE, 10'h200, WANT_PREDICTED, '0),
            item_row(MODE_SAMPLE, 10'h0FF, WANT_PREDICTED, '0),
            write_row(REG_H_MIN, 16'd100),
            write_row(REG_H_MAX, 16'd50),
            write_row(REG_H_STEP, 16'd1),
            write_row(REG_V_STEP, 16'd1),
            write_row(REG_V_MAX, 16'd1),
            item_row(MODE_START, 10'h000, WANT_NONE, '0),
            item_row(MODE_SAMPLE, 10'h111, WANT_PREDICTED, '0),
            item_row(MODE_SAMPLE, 10'h222, WANT_PREDICTED, '0),
            write_row(REG_MEAS_PER_POINT, 16'd2),
            write_row(REG_V_MAX, 16'hFFFF),
            item_row(MODE_START, 10'h000, WANT_NONE, '0),
            item_row(MODE_SAMPLE, 10'h001, WANT_PREDICTED, '0),
            item_row(MODE_SAMPLE, 10'h002, WANT_PREDICTED, '0),
            item_row(MODE_SAMPLE, 10'h004, WANT_PREDICTED, '0),
            item_row(MODE_SAMPLE, 10'h008, WANT_PREDICTED, '0),
            item_row(MODE_START, 10'h010, WANT_NONE, '0),
            item_row(MODE_SAMPLE, 10'h020, WANT_PREDICTED, '0),
            write_row(REG_MEAS_PER_POINT, 16'd255),
            item_row(MODE_START, 10'h000, WANT_NONE, '0),
            item_row(MODE_SAMPLE, 10'h040, WANT_PREDICTED, '0)
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                drain_results();
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                offer_item(plan[i].mode, plan[i].smp, produced, res);
                if (plan[i].want == WANT_GIVEN) begin
                    pending_labels.push_back(plan[i].expected);
                end else if (plan[i].want == WANT_PREDICTED && produced) begin
                    pending_labels.push_back(res);
                end
            end
        end

        for (int phase = 0; phase < 10; phase++) begin
            drain_results();
            vals[0] = 16'($urandom_range(3));
            base = 16'($urandom);
            vals[1] = base;
            vals[2] = base + 16'($urandom_range(1500));
            vals[3] = 16'($urandom_range(255));
            base = 16'($urandom);
            vals[4] = base;
            vals[5] = base + 16'($urandom_range(1500));
            vals[6] = 16'($urandom_range(1, 255));
            foreach (vals[k]) begin
                case ($urandom_range(9))
                    0: vals[k] = '0;
                    1: vals[k] = (k == 0 || k == 3 || k == 6) ? 16'h00FF : 16'hFFFF;
                    default: ;
                endcase
            end
            quota = 62;
            if (phase == 9) begin
                // A full point of 256 samples needs the longest phase.
                vals[0] = 16'h00FF;
                quota = 300;
            end
            write_reg(REG_MEAS_PER_POINT, vals[0]);
            write_reg(REG_H_MIN, vals[1]);
            write_reg(REG_H_MAX, vals[2]);
            write_reg(REG_H_STEP, vals[3]);
            write_reg(REG_V_MIN, vals[4]);
            write_reg(REG_V_MAX, vals[5]);
            write_reg(REG_V_STEP, vals[6]);
            steady <= (phase == 1);
            counted = 0;
            while (counted < quota) begin
                if (!scan_active) begin
                    m = ($urandom_range(9) < 8) ? MODE_START : MODE_SAMPLE;
                end else begin
                    m = ($urandom_range(99) < 3) ? MODE_START : MODE_SAMPLE;
                end
                offer_item(m, 10'($urandom_range(1023)), produced, res);
                if (produced) begin
                    pending_labels.push_back(res);
                end
                if (produced || m == MODE_START) begin
                    counted++;
                end
                if (phase == 3 && counted == 10) begin
                    hold_req <= ~hold_req;
                end
                if (phase == 5 && counted == 30) begin
                    drain_results();
                end
            end
        end

        drain_results();
        if (error_count == 0) begin
            $display("raster_scan_position_sequencer_test: done, clean");
        end else begin
            $display("raster_scan_position_sequencer_test: done, errors");
        end
        $finish;
    end

endmodule

>>> raster_scan_position_sequencer.f
design/rsps_pkg.sv
design/rsps_if.sv
design/rsps_cfg_regs.sv
design/raster_scan_position_sequencer.sv
bench/raster_scan_position_sequencer_test.sv
